@@ rtl/hrlf_pkg.sv @@
// Shared types and constants for the HID report LED field locator.
`default_nettype none
package hrlf_pkg;

  localparam int USAGE_SLOTS_DEF = 4;

  // Prefix byte that opens a long item
  localparam logic [7:0] LONG_PREFIX = 8'hFE;

  // Item types (prefix bits 3:2)
  localparam logic [1:0] TYPE_MAIN   = 2'd0;
  localparam logic [1:0] TYPE_GLOBAL = 2'd1;
  localparam logic [1:0] TYPE_LOCAL  = 2'd2;

  // Item tags (prefix bits 7:4)
  localparam logic [3:0] TAG_PAGE   = 4'h0;
  localparam logic [3:0] TAG_SIZE   = 4'h7;
  localparam logic [3:0] TAG_ID     = 4'h8;
  localparam logic [3:0] TAG_COUNT  = 4'h9;
  localparam logic [3:0] TAG_USAGE  = 4'h0;
  localparam logic [3:0] TAG_UMIN   = 4'h1;
  localparam logic [3:0] TAG_UMAX   = 4'h2;
  localparam logic [3:0] TAG_OUTPUT = 4'h9;

  localparam logic [15:0] PAGE_LED = 16'h0008;
  localparam logic [7:0]  ID_BASE_BITS = 8'd8;
  localparam logic [64:0] LED_BIT_LIMIT = 65'd64;

  // Commands from the item executor to the offset tracker
  localparam logic [1:0] CMD_NONE   = 2'd0;
  localparam logic [1:0] CMD_SET_ID = 2'd1;
  localparam logic [1:0] CMD_OUTPUT = 2'd2;

  // One assembled item (or a bare end-of-descriptor mark)
  typedef struct packed {
    logic        item;
    logic        last;
    logic [7:0]  prefix;
    logic [31:0] value;
  } evt_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        last;
    logic        led;
    logic [7:0]  id;
    logic [63:0] bits;
  } cmd_t;

endpackage
`default_nettype wire

@@ rtl/hrlf_front.sv @@
// Byte front end: assembles short items, skips long items.
`default_nettype none
module hrlf_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_byte,
  input  wire logic             in_last,
  output logic                  evt_valid,
  input  wire logic             evt_ready,
  output hrlf_pkg::evt_t        evt
);

  localparam logic [2:0] PH_PREFIX = 3'd0;
  localparam logic [2:0] PH_SHORT  = 3'd1;
  localparam logic [2:0] PH_LSIZE  = 3'd2;
  localparam logic [2:0] PH_LTAG   = 3'd3;
  localparam logic [2:0] PH_LDATA  = 3'd4;

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  prefix_r, prefix_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [31:0] value_r, value_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        accept;
  logic        done;
  logic [31:0] merged;

  assign in_ready = evt_ready;
  assign accept   = in_valid && in_ready;
  assign merged   = value_r | ({24'd0, in_byte} << {idx_r, 3'b000});

  always_comb begin
    phase_nxt  = phase_r;
    prefix_nxt = prefix_r;
    left_nxt   = left_r;
    value_nxt  = value_r;
    idx_nxt    = idx_r;
    done       = 1'b0;
    evt.prefix = prefix_r;
    evt.value  = merged;
    if (accept) begin
      unique case (phase_r)
        PH_PREFIX: begin
          if (in_byte == hrlf_pkg::LONG_PREFIX) begin
            phase_nxt = PH_LSIZE;
          end else begin
            prefix_nxt = in_byte;
            value_nxt  = '0;
            idx_nxt    = '0;
            left_nxt   = (in_byte[1:0] == 2'd3) ? 8'd4 : {6'd0, in_byte[1:0]};
            evt.prefix = in_byte;
            evt.value  = '0;
            if (in_byte[1:0] == 2'd0) begin
              done = 1'b1;
            end else begin
              phase_nxt = PH_SHORT;
            end
          end
        end
        PH_SHORT: begin
          value_nxt = merged;
          idx_nxt   = idx_r + 2'd1;
          left_nxt  = left_r - 8'd1;
          if (left_r == 8'd1) begin
            done      = 1'b1;
            phase_nxt = PH_PREFIX;
          end
        end
        PH_LSIZE: begin
          left_nxt  = in_byte;
          phase_nxt = PH_LTAG;
        end
        PH_LTAG: begin
          phase_nxt = (left_r == 8'd0) ? PH_PREFIX : PH_LDATA;
        end
        default: begin
          // Long item data: count down, return to prefix at zero
          if (left_r != 8'd0) begin
            left_nxt = left_r - 8'd1;
          end
          if (left_r <= 8'd1) begin
            phase_nxt = PH_PREFIX;
          end
        end
      endcase
      if (in_last) begin
        // Drop any partial item and restart
        phase_nxt  = PH_PREFIX;
        prefix_nxt = '0;
        left_nxt   = '0;
        value_nxt  = '0;
        idx_nxt    = '0;
      end
    end
    evt.item  = done;
    evt.last  = in_last;
    evt_valid = accept && (done || in_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_PREFIX;
      prefix_r <= '0;
      left_r   <= '0;
      value_r  <= '0;
      idx_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      prefix_r <= prefix_nxt;
      left_r   <= left_nxt;
      value_r  <= value_nxt;
      idx_r    <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/hrlf_queue.sv @@
// Two-entry item queue between the front end and the executor.
`default_nettype none
module hrlf_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire hrlf_pkg::evt_t push_evt,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output hrlf_pkg::evt_t      pop_evt
);

  hrlf_pkg::evt_t mem_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     count_r;
  logic           do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_evt    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/hrlf_exec.sv @@
// Item executor: global and local item state, Output field classification.
`default_nettype none
module hrlf_exec #(
  parameter int USAGE_SLOTS = hrlf_pkg::USAGE_SLOTS_DEF,
  localparam int FW = $clog2(USAGE_SLOTS + 1),
  localparam int DW = $clog2(USAGE_SLOTS)
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           evt_valid,
  output logic                evt_ready,
  input  wire hrlf_pkg::evt_t evt,
  output logic                cmd_valid,
  input  wire logic           cmd_ready,
  output hrlf_pkg::cmd_t      cmd,
  output logic [DW-1:0]       cmd_delta
);

  logic [15:0] page_r, page_nxt;
  logic [31:0] size_r, size_nxt;
  logic [31:0] count_r, count_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [15:0] ulist_r [USAGE_SLOTS];
  logic [15:0] ulist_nxt [USAGE_SLOTS];
  logic [FW-1:0] fill_r, fill_nxt;
  logic [15:0] ulow_r, ulow_nxt;
  logic [15:0] uhigh_r, uhigh_nxt;
  logic        low_seen_r, low_seen_nxt;
  logic        high_seen_r, high_seen_nxt;

  hrlf_pkg::cmd_t cmd_r, cmd_nxt;
  logic           cmd_v_r, cmd_v_nxt;
  logic [DW-1:0]  delta_r, delta_nxt;

  logic          take;
  logic [1:0]    ityp;
  logic [3:0]    itag;
  logic [31:0]   v;
  logic          led_base, range_ok, run_hit, led;
  logic [DW-1:0] run_k;

  assign evt_ready = !cmd_v_r || cmd_ready;
  assign take      = evt_valid && evt_ready;
  assign ityp      = evt.prefix[3:2];
  assign itag      = evt.prefix[7:4];
  assign v         = evt.value;
  assign cmd_valid = cmd_v_r;
  assign cmd       = cmd_r;
  assign cmd_delta = delta_r;

  // Classify the field an Output item would describe
  always_comb begin
    led_base = (page_r == hrlf_pkg::PAGE_LED) && (size_r == 32'd1) && (count_r >= 32'd3);
    range_ok = low_seen_r && high_seen_r && (ulow_r <= 16'd1) && (uhigh_r >= 16'd3);
    run_hit  = 1'b0;
    run_k    = '0;
    // Search downward so the lowest matching start wins
    for (int k = USAGE_SLOTS - 3; k >= 0; k--) begin
      if ((FW'(k + 2) < fill_r) && (ulist_r[k] == 16'd1) &&
          (ulist_r[k + 1] == 16'd2) && (ulist_r[k + 2] == 16'd3)) begin
        run_hit = 1'b1;
        run_k   = DW'(k);
      end
    end
    led = led_base && (range_ok || run_hit);
  end

  always_comb begin
    page_nxt      = page_r;
    size_nxt      = size_r;
    count_nxt     = count_r;
    id_nxt        = id_r;
    ulist_nxt     = ulist_r;
    fill_nxt      = fill_r;
    ulow_nxt      = ulow_r;
    uhigh_nxt     = uhigh_r;
    low_seen_nxt  = low_seen_r;
    high_seen_nxt = high_seen_r;
    cmd_nxt       = cmd_r;
    delta_nxt     = delta_r;
    cmd_v_nxt     = cmd_v_r && !cmd_ready;
    if (take) begin
      cmd_v_nxt    = 1'b1;
      cmd_nxt.kind = hrlf_pkg::CMD_NONE;
      cmd_nxt.last = evt.last;
      cmd_nxt.led  = led;
      cmd_nxt.id   = id_r;
      cmd_nxt.bits = size_r * count_r;
      delta_nxt    = range_ok ? ((ulow_r == 16'd0) ? DW'(1) : DW'(0)) : run_k;
      if (evt.item) begin
        unique case (ityp)
          hrlf_pkg::TYPE_GLOBAL: begin
            case (itag)
              hrlf_pkg::TAG_PAGE:  page_nxt  = v[15:0];
              hrlf_pkg::TAG_SIZE:  size_nxt  = v;
              hrlf_pkg::TAG_COUNT: count_nxt = v;
              hrlf_pkg::TAG_ID: begin
                id_nxt       = v[7:0];
                cmd_nxt.kind = hrlf_pkg::CMD_SET_ID;
                cmd_nxt.id   = v[7:0];
              end
              default: ;
            endcase
          end
          hrlf_pkg::TYPE_LOCAL: begin
            case (itag)
              hrlf_pkg::TAG_USAGE: begin
                // Ignore further usages once the list is full
                if (fill_r < FW'(USAGE_SLOTS)) begin
                  for (int i = 0; i < USAGE_SLOTS; i++) begin
                    if (FW'(i) == fill_r) begin
                      ulist_nxt[i] = v[15:0];
                    end
                  end
                  fill_nxt = fill_r + FW'(1);
                end
              end
              hrlf_pkg::TAG_UMIN: begin
                ulow_nxt     = v[15:0];
                low_seen_nxt = 1'b1;
              end
              hrlf_pkg::TAG_UMAX: begin
                uhigh_nxt     = v[15:0];
                high_seen_nxt = 1'b1;
              end
              default: ;
            endcase
          end
          hrlf_pkg::TYPE_MAIN: begin
            if (itag == hrlf_pkg::TAG_OUTPUT) begin
              cmd_nxt.kind = hrlf_pkg::CMD_OUTPUT;
            end
            for (int i = 0; i < USAGE_SLOTS; i++) begin
              ulist_nxt[i] = '0;
            end
            fill_nxt      = '0;
            low_seen_nxt  = 1'b0;
            high_seen_nxt = 1'b0;
          end
          default: ;
        endcase
      end
      if (evt.last) begin
        page_nxt  = '0;
        size_nxt  = '0;
        count_nxt = '0;
        id_nxt    = '0;
        for (int i = 0; i < USAGE_SLOTS; i++) begin
          ulist_nxt[i] = '0;
        end
        fill_nxt      = '0;
        ulow_nxt      = '0;
        uhigh_nxt     = '0;
        low_seen_nxt  = 1'b0;
        high_seen_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    delta_r <= delta_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r      <= '0;
      size_r      <= '0;
      count_r     <= '0;
      id_r        <= '0;
      for (int i = 0; i < USAGE_SLOTS; i++) begin
        ulist_r[i] <= '0;
      end
      fill_r      <= '0;
      ulow_r      <= '0;
      uhigh_r     <= '0;
      low_seen_r  <= 1'b0;
      high_seen_r <= 1'b0;
      cmd_v_r     <= 1'b0;
    end else begin
      page_r      <= page_nxt;
      size_r      <= size_nxt;
      count_r     <= count_nxt;
      id_r        <= id_nxt;
      ulist_r     <= ulist_nxt;
      fill_r      <= fill_nxt;
      ulow_r      <= ulow_nxt;
      uhigh_r     <= uhigh_nxt;
      low_seen_r  <= low_seen_nxt;
      high_seen_r <= high_seen_nxt;
      cmd_v_r     <= cmd_v_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/hrlf_track.sv @@
// Offset tracker: output bit offset, LED field record, result register.
`default_nettype none
module hrlf_track #(
  parameter int USAGE_SLOTS = hrlf_pkg::USAGE_SLOTS_DEF,
  localparam int DW = $clog2(USAGE_SLOTS)
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire hrlf_pkg::cmd_t cmd,
  input  wire logic [DW-1:0]  cmd_delta,
  output logic                res_valid,
  input  wire logic           res_ready,
  output logic                res_supported,
  output logic [7:0]          res_id,
  output logic [3:0]          res_bytes,
  output logic [5:0]          res_bit
);

  logic [31:0] off_r, off_nxt;
  logic        found_r, found_nxt;
  logic [7:0]  lid_r, lid_nxt;
  logic [3:0]  lbytes_r, lbytes_nxt;
  logic [5:0]  lbit_r, lbit_nxt;
  logic        out_v_r, out_v_nxt;
  logic        sup_r;
  logic [7:0]  oid_r;
  logic [3:0]  obytes_r;
  logic [5:0]  obit_r;

  logic        consume;
  logic [64:0] fend;
  logic [33:0] first2;
  logic [33:0] first;
  logic        record;

  // Hold an end-of-descriptor command while the previous result waits
  assign cmd_ready = !(cmd.last && out_v_r && !res_ready);
  assign consume   = cmd_valid && cmd_ready;

  assign fend   = {33'd0, off_r} + {1'b0, cmd.bits};
  assign first  = {2'd0, off_r} + {{(34 - DW){1'b0}}, cmd_delta};
  assign first2 = first + 34'd2;
  assign record = cmd.led && !found_r && (fend <= hrlf_pkg::LED_BIT_LIMIT) &&
                  (first2 < fend[33:0]);

  always_comb begin
    off_nxt    = off_r;
    found_nxt  = found_r;
    lid_nxt    = lid_r;
    lbytes_nxt = lbytes_r;
    lbit_nxt   = lbit_r;
    out_v_nxt  = out_v_r && !res_ready;
    if (consume) begin
      unique case (cmd.kind)
        hrlf_pkg::CMD_SET_ID: begin
          off_nxt = (cmd.id != 8'd0) ? {24'd0, hrlf_pkg::ID_BASE_BITS} : 32'd0;
        end
        hrlf_pkg::CMD_OUTPUT: begin
          if (record) begin
            found_nxt  = 1'b1;
            lid_nxt    = cmd.id;
            lbytes_nxt = 4'((fend[6:0] + 7'd7) >> 3);
            lbit_nxt   = first[5:0];
          end
          // Saturate the offset at all ones
          off_nxt = (fend[64:32] != 33'd0) ? 32'hFFFF_FFFF : fend[31:0];
        end
        default: ;
      endcase
      if (cmd.last) begin
        out_v_nxt  = 1'b1;
        off_nxt    = '0;
        found_nxt  = 1'b0;
        lid_nxt    = '0;
        lbytes_nxt = '0;
        lbit_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (consume && cmd.last) begin
      sup_r    <= found_nxt || (cmd.kind == hrlf_pkg::CMD_OUTPUT && record) || found_r;
      oid_r    <= (cmd.kind == hrlf_pkg::CMD_OUTPUT && record) ? cmd.id : lid_r;
      obytes_r <= (cmd.kind == hrlf_pkg::CMD_OUTPUT && record) ?
                  4'((fend[6:0] + 7'd7) >> 3) : lbytes_r;
      obit_r   <= (cmd.kind == hrlf_pkg::CMD_OUTPUT && record) ? first[5:0] : lbit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r    <= '0;
      found_r  <= 1'b0;
      lid_r    <= '0;
      lbytes_r <= '0;
      lbit_r   <= '0;
      out_v_r  <= 1'b0;
    end else begin
      off_r    <= off_nxt;
      found_r  <= found_nxt;
      lid_r    <= lid_nxt;
      lbytes_r <= lbytes_nxt;
      lbit_r   <= lbit_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  assign res_valid     = out_v_r;
  assign res_supported = sup_r;
  assign res_id        = oid_r;
  assign res_bytes     = obytes_r;
  assign res_bit       = obit_r;

endmodule
`default_nettype wire

@@ rtl/hid_report_led_field_locator.sv @@
// Top level of the HID report descriptor keyboard LED field locator.
//
// Usage: stream a HID report descriptor in on the in_ channel, one byte per
// transfer in in_tdata[7:0], with in_tlast on the final byte. When that byte has
// been taken, one result item leaves on the out_ channel saying whether a
// keyboard LED output field (page 8, one-bit entries, usages 1..3, inside
// the first 64 report bits) was found, its report id, the report length in
// bytes up to the field end and the bit position of Num Lock. All fields
// are zero when no such field exists.
// Throughput: one descriptor byte per cycle while the item queue has room. The
// front end decodes a byte in the cycle it is taken; the two-entry item queue,
// the executor (one 32x32 multiply per item) and the offset tracker each move
// one item per cycle unless the tracker holds a final command for the output.
// The last byte's item passes the queue, command and result registers in turn.
// Reset: rst_n clears all parser state; a descriptor starts fresh afterward,
// and the block also clears itself after every final byte.
// Stall: while out_tready is low a finished result holds in the output
// register; bytes of the next descriptor keep flowing until its own final
// byte reaches the tracker, after which in_tready drops once the queue fills.
`default_nettype none
module hid_report_led_field_locator #(
  parameter int USAGE_SLOTS = hrlf_pkg::USAGE_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // [0] supported, [8:1] report id,
                                       // [12:9] report bytes,
                                       // [18:13] Num Lock bit, [23:19] zero
);

  localparam int DW = $clog2(USAGE_SLOTS);

  hrlf_pkg::evt_t front_evt, queue_evt;
  logic           front_valid, front_ready;
  logic           queue_valid, queue_ready;
  hrlf_pkg::cmd_t cmd;
  logic           cmd_valid, cmd_ready;
  logic [DW-1:0]  cmd_delta;
  logic           res_supported;
  logic [7:0]     res_id;
  logic [3:0]     res_bytes;
  logic [5:0]     res_bit;

  // Assemble items from bytes
  hrlf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .evt_valid (front_valid),
    .evt_ready (front_ready),
    .evt       (front_evt)
  );

  // Decouple byte intake from item execution
  hrlf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_evt   (front_evt),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_evt    (queue_evt)
  );

  // Apply global and local items, classify Output fields
  hrlf_exec #(
    .USAGE_SLOTS (USAGE_SLOTS)
  ) u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt_valid (queue_valid),
    .evt_ready (queue_ready),
    .evt       (queue_evt),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .cmd_delta (cmd_delta)
  );

  // Advance the bit offset, record the LED field, hold the result
  hrlf_track #(
    .USAGE_SLOTS (USAGE_SLOTS)
  ) u_track (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd),
    .cmd_delta     (cmd_delta),
    .res_valid     (out_tvalid),
    .res_ready     (out_tready),
    .res_supported (res_supported),
    .res_id        (res_id),
    .res_bytes     (res_bytes),
    .res_bit       (res_bit)
  );

  assign out_tdata = {5'd0, res_bit, res_bytes, res_id, res_supported};

endmodule
`default_nettype wire
